// ----- hdl/lpm_pkg.sv -----
// ============================================================================
// lpm_pkg: shared types, constants and tables of the led pattern beacon
// Holds the register map, mode codes, divider control, the sequencer
// microcode and the morse character table.
// ============================================================================
package lpm_pkg;

    // message and datapath sizes
    localparam int MSG_CHARS    = 32;
    localparam int MSG_BYTES    = 32;
    localparam int BYTE_IDX_W   = 5;
    localparam int CHAR_CNT_W   = 6;
    localparam int DATA_W       = 32;
    localparam int DIV_W        = 17;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 64;

    // morse timing in units
    localparam int CHAR_LEN_MAX = 22;
    localparam int CHAR_LEN_W   = 5;
    localparam int PAUSE_UNITS  = 4;
    localparam int SPACE_UNITS  = 7;
    localparam int LETTER_GAP   = 3;

    // register reset values
    localparam logic [15:0] DEFAULT_UNIT_MS = 16'd200;
    localparam logic [15:0] RST_BLINK_MS    = 16'd500;
    localparam logic [63:0] RST_MSG_0_7     = 64'h0000_0000_0053_4F53;

    // register map
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_PATTERN_MODE,
        REG_UNIT_MS,
        REG_BLINK_ON_MS,
        REG_BLINK_OFF_MS,
        REG_MSG_0_7,
        REG_MSG_8_15,
        REG_MSG_16_23,
        REG_MSG_24_31
    } cfg_reg_t;

    // pattern modes
    typedef enum logic [1:0] {
        MODE_OFF,
        MODE_SOLID,
        MODE_BLINK,
        MODE_MORSE
    } mode_t;

    // divider control group
    typedef struct packed {
        logic load;
        logic step;
    } div_ctrl_t;

    // microcode operations
    typedef enum logic [3:0] {
        OP_NOP,
        OP_LOAD_ITEM,
        OP_DIV_PERIOD,
        OP_DIV_UNIT,
        OP_DIV_TOTAL,
        OP_DIV_STEP,
        OP_RES_BLINK,
        OP_RES_MODE,
        OP_WALK_TOTAL,
        OP_WALK_PROBE,
        OP_PUSH
    } uop_t;

    // microcode jump conditions
    typedef enum logic [3:0] {
        COND_NEVER,
        COND_ALWAYS,
        COND_NO_ITEM,
        COND_MORSE,
        COND_NOT_BLINK,
        COND_PERIOD_ZERO,
        COND_DIV_MORE,
        COND_WALK_MORE,
        COND_PROBE_MORE,
        COND_OUT_BUSY
    } cond_t;

    localparam int UPC_W = 4;

    typedef struct packed {
        uop_t             op;
        cond_t            cond;
        logic [UPC_W-1:0] target;
    } ucw_t;

    // program steps
    localparam logic [UPC_W-1:0] S_IDLE       = 4'd0;
    localparam logic [UPC_W-1:0] S_CHK_MORSE  = 4'd1;
    localparam logic [UPC_W-1:0] S_CHK_BLINK  = 4'd2;
    localparam logic [UPC_W-1:0] S_CHK_PERIOD = 4'd3;
    localparam logic [UPC_W-1:0] S_BLINK_LOAD = 4'd4;
    localparam logic [UPC_W-1:0] S_BLINK_DIV  = 4'd5;
    localparam logic [UPC_W-1:0] S_BLINK_RES  = 4'd6;
    localparam logic [UPC_W-1:0] S_MODE_RES   = 4'd7;
    localparam logic [UPC_W-1:0] S_MORSE_LOAD = 4'd8;
    localparam logic [UPC_W-1:0] S_UNIT_DIV   = 4'd9;
    localparam logic [UPC_W-1:0] S_WALK_TOTAL = 4'd10;
    localparam logic [UPC_W-1:0] S_TOTAL_LOAD = 4'd11;
    localparam logic [UPC_W-1:0] S_TOTAL_DIV  = 4'd12;
    localparam logic [UPC_W-1:0] S_WALK_PROBE = 4'd13;
    localparam logic [UPC_W-1:0] S_OUT        = 4'd14;
    localparam logic [UPC_W-1:0] S_RETURN     = 4'd15;

    // microcode rom: a jump is taken when its condition holds, else next step
    function automatic ucw_t ucode_rom(input logic [UPC_W-1:0] addr);
        ucw_t w;
        case (addr)
            S_IDLE:       w = '{OP_LOAD_ITEM,  COND_NO_ITEM,     S_IDLE};
            S_CHK_MORSE:  w = '{OP_NOP,        COND_MORSE,       S_MORSE_LOAD};
            S_CHK_BLINK:  w = '{OP_NOP,        COND_NOT_BLINK,   S_MODE_RES};
            S_CHK_PERIOD: w = '{OP_NOP,        COND_PERIOD_ZERO, S_MODE_RES};
            S_BLINK_LOAD: w = '{OP_DIV_PERIOD, COND_NEVER,       S_IDLE};
            S_BLINK_DIV:  w = '{OP_DIV_STEP,   COND_DIV_MORE,    S_BLINK_DIV};
            S_BLINK_RES:  w = '{OP_RES_BLINK,  COND_ALWAYS,      S_OUT};
            S_MODE_RES:   w = '{OP_RES_MODE,   COND_ALWAYS,      S_OUT};
            S_MORSE_LOAD: w = '{OP_DIV_UNIT,   COND_NEVER,       S_IDLE};
            S_UNIT_DIV:   w = '{OP_DIV_STEP,   COND_DIV_MORE,    S_UNIT_DIV};
            S_WALK_TOTAL: w = '{OP_WALK_TOTAL, COND_WALK_MORE,   S_WALK_TOTAL};
            S_TOTAL_LOAD: w = '{OP_DIV_TOTAL,  COND_NEVER,       S_IDLE};
            S_TOTAL_DIV:  w = '{OP_DIV_STEP,   COND_DIV_MORE,    S_TOTAL_DIV};
            S_WALK_PROBE: w = '{OP_WALK_PROBE, COND_PROBE_MORE,  S_WALK_PROBE};
            S_OUT:        w = '{OP_PUSH,       COND_OUT_BUSY,    S_OUT};
            S_RETURN:     w = '{OP_NOP,        COND_ALWAYS,      S_IDLE};
            default:      w = '{OP_NOP,        COND_ALWAYS,      S_IDLE};
        endcase
        return w;
    endfunction

    // symbol list of one letter or digit: count and dash flags, symbol 0 in bit 0
    typedef struct packed {
        logic [2:0] count;
        logic [4:0] dash;
    } morse_sym_t;

    // timing of one character: length in units and lit flag per unit
    typedef struct packed {
        logic [CHAR_LEN_W-1:0]   len;
        logic [CHAR_LEN_MAX-1:0] mask;
    } char_code_t;

    function automatic morse_sym_t morse_sym(input logic [7:0] b);
        morse_sym_t s;
        case (b)
            "A":     s = '{3'd2, 5'b00010};
            "B":     s = '{3'd4, 5'b00001};
            "C":     s = '{3'd4, 5'b00101};
            "D":     s = '{3'd3, 5'b00001};
            "E":     s = '{3'd1, 5'b00000};
            "F":     s = '{3'd4, 5'b00100};
            "G":     s = '{3'd3, 5'b00011};
            "H":     s = '{3'd4, 5'b00000};
            "I":     s = '{3'd2, 5'b00000};
            "J":     s = '{3'd4, 5'b01110};
            "K":     s = '{3'd3, 5'b00101};
            "L":     s = '{3'd4, 5'b00010};
            "M":     s = '{3'd2, 5'b00011};
            "N":     s = '{3'd2, 5'b00001};
            "O":     s = '{3'd3, 5'b00111};
            "P":     s = '{3'd4, 5'b00110};
            "Q":     s = '{3'd4, 5'b01011};
            "R":     s = '{3'd3, 5'b00010};
            "S":     s = '{3'd3, 5'b00000};
            "T":     s = '{3'd1, 5'b00001};
            "U":     s = '{3'd3, 5'b00100};
            "V":     s = '{3'd4, 5'b01000};
            "W":     s = '{3'd3, 5'b00110};
            "X":     s = '{3'd4, 5'b01001};
            "Y":     s = '{3'd4, 5'b01101};
            "Z":     s = '{3'd4, 5'b00011};
            "0":     s = '{3'd5, 5'b11111};
            "1":     s = '{3'd5, 5'b11110};
            "2":     s = '{3'd5, 5'b11100};
            "3":     s = '{3'd5, 5'b11000};
            "4":     s = '{3'd5, 5'b10000};
            "5":     s = '{3'd5, 5'b00000};
            "6":     s = '{3'd5, 5'b00001};
            "7":     s = '{3'd5, 5'b00011};
            "8":     s = '{3'd5, 5'b00111};
            "9":     s = '{3'd5, 5'b01111};
            default: s = '{3'd0, 5'b00000};
        endcase
        return s;
    endfunction

    // character timing table, indexed by the raw message byte
    function automatic char_code_t char_code(input logic [7:0] raw);
        char_code_t           c;
        morse_sym_t           s;
        logic [7:0]           b;
        logic [CHAR_LEN_W-1:0] pos;
        b    = raw;
        pos  = '0;
        c.mask = '0;
        // fold lower case onto upper case
        if (b inside {[8'h61:8'h7A]}) begin
            b = b - 8'h20;
        end
        s = morse_sym(b);
        if (b == 8'h20) begin
            pos = CHAR_LEN_W'(SPACE_UNITS);
        end
        else begin
            for (int j = 0; j < 5; j++) begin
                if (3'(j) < s.count) begin
                    // one dark unit between symbols
                    if (j != 0) begin
                        pos = pos + 5'd1;
                    end
                    if (s.dash[j]) begin
                        c.mask[pos]        = 1'b1;
                        c.mask[pos + 5'd1] = 1'b1;
                        c.mask[pos + 5'd2] = 1'b1;
                        pos = pos + 5'd3;
                    end
                    else begin
                        c.mask[pos] = 1'b1;
                        pos = pos + 5'd1;
                    end
                end
            end
            pos = pos + CHAR_LEN_W'(LETTER_GAP);
        end
        c.len = pos;
        return c;
    endfunction

endpackage

// ----- hdl/led_pattern_morse_generator_top.sv -----
// ============================================================================
// led_pattern_morse_generator_top: led beacon for off, solid, blink and morse
// Answers for each elapsed time whether the led is lit in the current mode.
// ============================================================================
// One result per item. A microcoded sequencer (16-step rom) drives a shared
// 32-step bit-serial divider and a character walker that handles one message
// byte per cycle. Off and solid need no division and blink runs one division;
// morse runs two 32-step divisions and two walks over the message, one over all
// n bytes (the message length in bytes) and one over the k bytes walked before
// the sampled unit is found. A new item is taken while the previous result
// still waits in the output register.
module led_pattern_morse_generator_top #(
    parameter int MSG_CHARS = lpm_pkg::MSG_CHARS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // item channel
    input  logic                              item_valid,
    output logic                              item_stall,
    input  logic [lpm_pkg::DATA_W-1:0]        sample_ms,
    // result channel
    output logic                              result_valid,
    input  logic                              result_stall,
    output logic                              led_on,
    // configuration channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [lpm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [lpm_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int ACC_W = $clog2(MSG_CHARS * lpm_pkg::CHAR_LEN_MAX
                                  + lpm_pkg::PAUSE_UNITS + 1);

    // configuration registers
    lpm_pkg::mode_t mode_reg;
    logic [15:0]    unit_reg;
    logic [15:0]    on_reg;
    logic [15:0]    off_reg;
    logic [63:0]    msg0_reg;
    logic [63:0]    msg1_reg;
    logic [63:0]    msg2_reg;
    logic [63:0]    msg3_reg;

    // sequencer and datapath registers
    logic [lpm_pkg::UPC_W-1:0]      upc_reg, upc_next;
    logic [lpm_pkg::DATA_W-1:0]     elapsed_reg, elapsed_next;
    logic [lpm_pkg::CHAR_CNT_W-1:0] idx_reg, idx_next;
    logic [ACC_W-1:0]               acc_reg, acc_next;
    logic                           res_reg, res_next;
    logic                           out_valid_reg, out_valid_next;
    logic                           led_reg, led_next;

    // datapath signals
    lpm_pkg::ucw_t                  ucw;
    logic                           jump;
    lpm_pkg::div_ctrl_t             div_ctrl;
    logic [lpm_pkg::DATA_W-1:0]     div_dividend;
    logic [lpm_pkg::DIV_W-1:0]      div_divisor;
    logic [lpm_pkg::DATA_W-1:0]     div_quotient;
    logic [lpm_pkg::DIV_W-1:0]      div_remainder;
    logic                           div_last;
    logic [lpm_pkg::DIV_W-1:0]      period;
    logic [15:0]                    unit_eff;
    logic [lpm_pkg::MSG_BYTES*8-1:0] msg_flat;
    logic [7:0]                     msg_bytes [lpm_pkg::MSG_BYTES];
    logic [7:0]                     cur_byte;
    lpm_pkg::char_code_t            code;
    logic                           walk_end;
    logic [ACC_W-1:0]               acc_sum;
    logic [ACC_W-1:0]               total;
    logic [ACC_W-1:0]               t_val;
    logic [ACC_W-1:0]               t_off;
    logic                           probe_hit;
    logic                           out_busy;

    // configuration write port, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= lpm_pkg::MODE_OFF;
            unit_reg <= lpm_pkg::DEFAULT_UNIT_MS;
            on_reg   <= lpm_pkg::RST_BLINK_MS;
            off_reg  <= lpm_pkg::RST_BLINK_MS;
            msg0_reg <= lpm_pkg::RST_MSG_0_7;
            msg1_reg <= '0;
            msg2_reg <= '0;
            msg3_reg <= '0;
        end
        else if (cfg_valid && cfg_ready) begin
            case (lpm_pkg::cfg_reg_t'(cfg_index))
                lpm_pkg::REG_PATTERN_MODE: mode_reg <= lpm_pkg::mode_t'(cfg_data[1:0]);
                lpm_pkg::REG_UNIT_MS:      unit_reg <= cfg_data[15:0];
                lpm_pkg::REG_BLINK_ON_MS:  on_reg   <= cfg_data[15:0];
                lpm_pkg::REG_BLINK_OFF_MS: off_reg  <= cfg_data[15:0];
                lpm_pkg::REG_MSG_0_7:      msg0_reg <= cfg_data;
                lpm_pkg::REG_MSG_8_15:     msg1_reg <= cfg_data;
                lpm_pkg::REG_MSG_16_23:    msg2_reg <= cfg_data;
                lpm_pkg::REG_MSG_24_31:    msg3_reg <= cfg_data;
                default:                   mode_reg <= mode_reg;
            endcase
        end
    end

    // derived operands
    assign period   = {1'b0, on_reg} + {1'b0, off_reg};
    assign unit_eff = (unit_reg == 16'd0) ? lpm_pkg::DEFAULT_UNIT_MS : unit_reg;
    assign msg_flat = {msg3_reg, msg2_reg, msg1_reg, msg0_reg};

    always_comb
    begin
        for (int k = 0; k < lpm_pkg::MSG_BYTES; k++) begin
            msg_bytes[k] = msg_flat[8*k +: 8];
        end
    end

    // character walker
    assign cur_byte  = msg_bytes[idx_reg[lpm_pkg::BYTE_IDX_W-1:0]];
    assign code      = lpm_pkg::char_code(cur_byte);
    assign walk_end  = (idx_reg == lpm_pkg::CHAR_CNT_W'(MSG_CHARS)) || (cur_byte == 8'h00);
    assign acc_sum   = acc_reg + ACC_W'(code.len);
    assign total     = acc_reg + ACC_W'(lpm_pkg::PAUSE_UNITS);
    assign t_val     = div_remainder[ACC_W-1:0];
    assign t_off     = t_val - acc_reg;
    assign probe_hit = (t_val < acc_sum);
    assign out_busy  = out_valid_reg && result_stall;

    // shared divider
    lpm_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl      (div_ctrl),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .quotient  (div_quotient),
        .remainder (div_remainder),
        .last      (div_last)
    );

    // microcode fetch and jump decision
    assign ucw = lpm_pkg::ucode_rom(upc_reg);

    always_comb
    begin
        case (ucw.cond)
            lpm_pkg::COND_NEVER:       jump = 1'b0;
            lpm_pkg::COND_ALWAYS:      jump = 1'b1;
            lpm_pkg::COND_NO_ITEM:     jump = !item_valid;
            lpm_pkg::COND_MORSE:       jump = (mode_reg == lpm_pkg::MODE_MORSE);
            lpm_pkg::COND_NOT_BLINK:   jump = (mode_reg != lpm_pkg::MODE_BLINK);
            lpm_pkg::COND_PERIOD_ZERO: jump = (period == '0);
            lpm_pkg::COND_DIV_MORE:    jump = !div_last;
            lpm_pkg::COND_WALK_MORE:   jump = !walk_end;
            lpm_pkg::COND_PROBE_MORE:  jump = !walk_end && !probe_hit;
            lpm_pkg::COND_OUT_BUSY:    jump = out_busy;
            default:                   jump = 1'b0;
        endcase
    end

    // control word decode into next values
    always_comb
    begin
        upc_next       = jump ? ucw.target : upc_reg + 1'b1;
        elapsed_next   = elapsed_reg;
        idx_next       = idx_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        led_next       = led_reg;
        out_valid_next = out_valid_reg && result_stall;
        div_ctrl       = '0;
        div_dividend   = elapsed_reg;
        div_divisor    = period;
        case (ucw.op)
            lpm_pkg::OP_NOP: ;
            lpm_pkg::OP_LOAD_ITEM:
            begin
                if (item_valid) begin
                    elapsed_next = sample_ms;
                end
            end
            lpm_pkg::OP_DIV_PERIOD:
            begin
                div_ctrl.load = 1'b1;
            end
            lpm_pkg::OP_DIV_UNIT:
            begin
                div_ctrl.load = 1'b1;
                div_divisor   = {1'b0, unit_eff};
                idx_next      = '0;
                acc_next      = '0;
            end
            lpm_pkg::OP_DIV_TOTAL:
            begin
                div_ctrl.load = 1'b1;
                div_dividend  = div_quotient;
                div_divisor   = lpm_pkg::DIV_W'(total);
                idx_next      = '0;
                acc_next      = '0;
            end
            lpm_pkg::OP_DIV_STEP:
            begin
                div_ctrl.step = 1'b1;
            end
            lpm_pkg::OP_RES_BLINK:
            begin
                res_next = (div_remainder < {1'b0, on_reg});
            end
            lpm_pkg::OP_RES_MODE:
            begin
                res_next = (mode_reg == lpm_pkg::MODE_SOLID);
            end
            lpm_pkg::OP_WALK_TOTAL:
            begin
                if (!walk_end) begin
                    acc_next = acc_sum;
                    idx_next = idx_reg + 1'b1;
                end
            end
            lpm_pkg::OP_WALK_PROBE:
            begin
                // past the last byte lies the dark pause
                if (walk_end) begin
                    res_next = 1'b0;
                end
                else if (probe_hit) begin
                    res_next = code.mask[t_off[lpm_pkg::CHAR_LEN_W-1:0]];
                end
                else begin
                    acc_next = acc_sum;
                    idx_next = idx_reg + 1'b1;
                end
            end
            lpm_pkg::OP_PUSH:
            begin
                if (!out_busy) begin
                    out_valid_next = 1'b1;
                    led_next       = res_reg;
                end
            end
            default: ;
        endcase
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            upc_reg       <= lpm_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
            idx_reg       <= '0;
            acc_reg       <= '0;
        end
        else begin
            upc_reg       <= upc_next;
            out_valid_reg <= out_valid_next;
            idx_reg       <= idx_next;
            acc_reg       <= acc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        elapsed_reg <= elapsed_next;
        res_reg     <= res_next;
        led_reg     <= led_next;
    end

    // port drive
    assign item_stall   = (upc_reg != lpm_pkg::S_IDLE);
    assign result_valid = out_valid_reg;
    assign led_on       = led_reg;

    // an accepted transaction moves the sequencer off the idle step
    a_accept_leaves_idle: assert property (
        @(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> (upc_reg != lpm_pkg::S_IDLE)
    ) else $error("sequencer stayed idle after an accepted transaction");

    // a new result appears only from the output step
    a_result_from_out_step: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(result_valid) |-> ($past(upc_reg) == lpm_pkg::S_OUT)
    ) else $error("result raised outside the output step");

    // the blink compare sees a finished division
    a_blink_after_div: assert property (
        @(posedge clk) disable iff (!rst_n)
        (upc_reg == lpm_pkg::S_BLINK_RES) |-> $past(div_last)
    ) else $error("blink result taken before the division finished");

    // the probed unit never lies before the current character
    a_probe_not_behind: assert property (
        @(posedge clk) disable iff (!rst_n)
        (upc_reg == lpm_pkg::S_WALK_PROBE) |-> (t_val >= acc_reg)
    ) else $error("morse probe walked past the sampled unit");

endmodule

// ----- hdl/lpm_div.sv -----
// ============================================================================
// lpm_div: shared restoring divider, one quotient bit per cycle
// Loads dividend and divisor, then runs DATA_W steps under sequencer control.
// ============================================================================
module lpm_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  lpm_pkg::div_ctrl_t            ctrl,
    input  logic [lpm_pkg::DATA_W-1:0]    dividend,
    input  logic [lpm_pkg::DIV_W-1:0]     divisor,
    output logic [lpm_pkg::DATA_W-1:0]    quotient,
    output logic [lpm_pkg::DIV_W-1:0]     remainder,
    output logic                          last
);

    localparam int CNT_W = $clog2(lpm_pkg::DATA_W);

    logic [lpm_pkg::DATA_W-1:0] quo_reg;
    logic [lpm_pkg::DIV_W-1:0]  rem_reg;
    logic [lpm_pkg::DIV_W-1:0]  dsr_reg;
    logic [CNT_W-1:0]           cnt_reg;

    logic [lpm_pkg::DIV_W:0]    rem_shift;
    logic [lpm_pkg::DIV_W:0]    rem_diff;
    logic                       fits;

    // trial subtract of the shifted partial remainder
    assign rem_shift = {rem_reg, quo_reg[lpm_pkg::DATA_W-1]};
    assign rem_diff  = rem_shift - {1'b0, dsr_reg};
    assign fits      = (rem_shift >= {1'b0, dsr_reg});

    // step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= '0;
        end
        else if (ctrl.load) begin
            cnt_reg <= '0;
        end
        else if (ctrl.step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // quotient, remainder and divisor
    always_ff @(posedge clk)
    begin
        if (ctrl.load) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (ctrl.step) begin
            quo_reg <= {quo_reg[lpm_pkg::DATA_W-2:0], fits};
            rem_reg <= fits ? rem_diff[lpm_pkg::DIV_W-1:0] : rem_shift[lpm_pkg::DIV_W-1:0];
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign last      = (cnt_reg == CNT_W'(lpm_pkg::DATA_W - 1));

endmodule
